>>> hw/rtl/multichannel_matrix_mixer_macros.svh
// Assertion helpers for the matrix mixer checker
`ifndef MULTICHANNEL_MATRIX_MIXER_MACROS_SVH
`define MULTICHANNEL_MATRIX_MIXER_MACROS_SVH

// same-cycle implication, masked during reset
`define MMM_CHK_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("mixer check failed");

// next-cycle implication, masked during reset
`define MMM_CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("mixer check failed");

// next-cycle implication, also active while reset is applied
`define MMM_CHK_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("mixer reset check failed");

`endif

>>> hw/rtl/mmm_pkg.sv
package mmm_pkg;

  localparam int unsigned LANES  = 16;
  localparam int unsigned ROWS   = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned PROD_W = SMP_W + COEF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned FRAC   = 14;

  typedef logic signed [SMP_W-1:0]    smp_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [2*COEF_W-1:0]        cword_t;  // {im, re}

  typedef enum logic [1:0] {
    CFG_IN_CH  = 2'd0,
    CFG_OUT_CH = 2'd1,
    CFG_CPLX   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  // per-sample control carried down the pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             gap;
    logic             cplx;
    logic [CNT_W-1:0] n_out;
  } pctl_t;

  // channel count: zero reads as one, anything above 16 as 16
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(LANES)) r = CNT_W'(LANES);
    return r;
  endfunction

  // round half up by 2^-14 then saturate to Q1.15
  function automatic smp_t round_sat(input acc_t a);
    logic signed [ACC_W:0]     t;
    logic [ACC_W-FRAC:0]       r;
    smp_t                      o;
    t = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (FRAC-1));
    r = t[ACC_W:FRAC];
    if ((&r[ACC_W-FRAC:SMP_W-1]) || ~(|r[ACC_W-FRAC:SMP_W-1])) o = r[SMP_W-1:0];
    else if (r[ACC_W-FRAC]) o = {1'b1, {(SMP_W-1){1'b0}}};
    else o = {1'b0, {(SMP_W-1){1'b1}}};
    return o;
  endfunction

endpackage

>>> hw/rtl/mmm_coef_ram.sv
// Coefficient store: one row per input channel, column-masked writes,
// whole-row registered reads. Unwritten entries read as zero.
module mmm_coef_ram (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [mmm_pkg::IDX_W-1:0]    wrow,
  input  logic [mmm_pkg::IDX_W-1:0]    wcol,
  input  mmm_pkg::cword_t              wdata,
  input  logic                         re,
  input  logic [mmm_pkg::IDX_W-1:0]    rrow,
  output mmm_pkg::cword_t              rdata [mmm_pkg::LANES]
);

  mmm_pkg::cword_t            mem [mmm_pkg::ROWS][mmm_pkg::LANES];
  mmm_pkg::cword_t            rd_r [mmm_pkg::LANES];
  logic [mmm_pkg::LANES-1:0]  vld_r [mmm_pkg::ROWS];
  logic [mmm_pkg::LANES-1:0]  rvld_r;

  // array write and row read
  always_ff @(posedge clk) begin
    if (we) mem[wrow][wcol] <= wdata;
    if (re) rd_r <= mem[rrow];
  end

  // per-entry written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmm_pkg::ROWS; i++) vld_r[i] <= '0;
      rvld_r <= '0;
    end else begin
      if (we) vld_r[wrow][wcol] <= 1'b1;
      if (re) rvld_r <= vld_r[rrow];
    end
  end

  always_comb begin
    for (int j = 0; j < mmm_pkg::LANES; j++)
      rdata[j] = rvld_r[j] ? rd_r[j] : '0;
  end

endmodule

>>> hw/rtl/mmm_mac.sv
// Multiply stage then accumulate stage, one lane per output channel.
module mmm_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  mmm_pkg::pctl_t       s1_ctl,
  input  mmm_pkg::smp_t        s1_re,
  input  mmm_pkg::smp_t        s1_im,
  input  mmm_pkg::cword_t      coef [mmm_pkg::LANES],
  output mmm_pkg::pctl_t       s2_ctl,
  output mmm_pkg::acc_t        acc_re_nxt [mmm_pkg::LANES],
  output mmm_pkg::acc_t        acc_im_nxt [mmm_pkg::LANES]
);

  mmm_pkg::pctl_t  s2_ctl_r;
  mmm_pkg::prod_t  prr_r [mmm_pkg::LANES];
  mmm_pkg::prod_t  pii_r [mmm_pkg::LANES];
  mmm_pkg::prod_t  pri_r [mmm_pkg::LANES];
  mmm_pkg::prod_t  pir_r [mmm_pkg::LANES];
  mmm_pkg::acc_t   acc_re_r [mmm_pkg::LANES];
  mmm_pkg::acc_t   acc_im_r [mmm_pkg::LANES];

  assign s2_ctl = s2_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_ctl_r.valid <= 1'b0;
    else if (en) s2_ctl_r <= s1_ctl;
  end

  // four partial products per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < mmm_pkg::LANES; j++) begin
        prr_r[j] <= s1_re * mmm_pkg::coef_t'(coef[j][mmm_pkg::COEF_W-1:0]);
        pii_r[j] <= s1_im * mmm_pkg::coef_t'(coef[j][2*mmm_pkg::COEF_W-1:mmm_pkg::COEF_W]);
        pri_r[j] <= s1_re * mmm_pkg::coef_t'(coef[j][2*mmm_pkg::COEF_W-1:mmm_pkg::COEF_W]);
        pir_r[j] <= s1_im * mmm_pkg::coef_t'(coef[j][mmm_pkg::COEF_W-1:0]);
      end
    end
  end

  // combine and accumulate; first channel of a frame restarts the sum
  always_comb begin
    logic signed [mmm_pkg::SUM_W-1:0] p_re;
    logic signed [mmm_pkg::SUM_W-1:0] p_im;
    for (int j = 0; j < mmm_pkg::LANES; j++) begin
      p_re = mmm_pkg::SUM_W'(prr_r[j]) - mmm_pkg::SUM_W'(pii_r[j]);
      p_im = s2_ctl_r.cplx ? mmm_pkg::SUM_W'(pri_r[j]) + mmm_pkg::SUM_W'(pir_r[j]) : '0;
      acc_re_nxt[j] = (s2_ctl_r.first ? '0 : acc_re_r[j]) + mmm_pkg::ACC_W'(p_re);
      acc_im_nxt[j] = (s2_ctl_r.first ? '0 : acc_im_r[j]) + mmm_pkg::ACC_W'(p_im);
    end
  end

  // lanes past the output count keep their sums; all start at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < mmm_pkg::LANES; j++) begin
        acc_re_r[j] <= '0;
        acc_im_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < mmm_pkg::LANES; j++) begin
        if (en && s2_ctl_r.valid && (mmm_pkg::CNT_W'(j) < s2_ctl_r.n_out)) begin
          acc_re_r[j] <= acc_re_nxt[j];
          acc_im_r[j] <= acc_im_nxt[j];
        end
      end
    end
  end

endmodule

>>> hw/rtl/mmm_emit.sv
// Frame buffer, output register: drains one channel per cycle unless stalled.
module mmm_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mmm_pkg::pctl_t       ctl,
  input  mmm_pkg::acc_t        sum_re [mmm_pkg::LANES],
  input  mmm_pkg::acc_t        sum_im [mmm_pkg::LANES],
  output logic                 busy,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,
  output logic                 out_tlast
);

  mmm_pkg::acc_t                buf_re_r [mmm_pkg::LANES];
  mmm_pkg::acc_t                buf_im_r [mmm_pkg::LANES];
  logic                         bvld_r;
  logic                         bgap_r;
  logic                         bcplx_r;
  logic [mmm_pkg::CNT_W-1:0]    bn_r;
  logic [mmm_pkg::IDX_W-1:0]    bidx_r;
  logic                         ov_r;
  logic                         olast_r;
  logic [mmm_pkg::IDX_W-1:0]    och_r;
  mmm_pkg::smp_t                ore_r;
  mmm_pkg::smp_t                oim_r;
  logic                         take;
  logic                         blast;

  // buffer frees up on the edge its last channel moves to the output register
  assign busy  = bvld_r && !(take && blast);
  assign take  = bvld_r && (!ov_r || out_tready);
  assign blast = (mmm_pkg::CNT_W'(bidx_r) + mmm_pkg::CNT_W'(1)) == bn_r;

  always_ff @(posedge clk) begin
    if (load) begin
      buf_re_r <= sum_re;
      buf_im_r <= sum_im;
      bgap_r   <= ctl.gap;
      bcplx_r  <= ctl.cplx;
      bn_r     <= ctl.n_out;
    end
  end

  // buffer walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r <= 1'b0;
      bidx_r <= '0;
    end else if (load) begin
      bvld_r <= 1'b1;
      bidx_r <= '0;
    end else if (take) begin
      bvld_r <= !blast;
      bidx_r <= bidx_r + mmm_pkg::IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (take) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      och_r   <= bidx_r;
      olast_r <= blast;
      ore_r   <= bgap_r ? '0 : mmm_pkg::round_sat(buf_re_r[bidx_r]);
      oim_r   <= (bgap_r || !bcplx_r) ? '0 : mmm_pkg::round_sat(buf_im_r[bidx_r]);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {4'b0000, oim_r, ore_r, och_r};

endmodule

>>> hw/rtl/multichannel_matrix_mixer.sv
// Matrix mixer: output frame = input frame times a coefficient matrix.
// Input stream carries either one channel sample or one coefficient write,
// selected by in_tuser[0]; in_tuser[1] flags a gap sample. Samples of a frame
// arrive channel 0 first. On the last channel the block emits one result per
// configured output channel on the out stream, channel 0 first, out_tlast on
// the final one.
// Config writes (cfg_index 0 input channels, 1 output channels, 2 complex
// mode) are always taken; write them only while the block is idle.
// One input request per cycle unless the pipeline holds. Last sample to first
// result passes coefficient row read, multiply, accumulate and output
// register. A frame's results leave at one per cycle unless stalled, so
// frames shorter than their output count are paced by the result drain: the
// pipeline holds while a finished frame waits for the single frame buffer.
// Reset clears counters, accumulators, valid flags and the coefficient written
// flags, so the matrix reads as zero. When the receiver stalls, the output
// register holds its result and the input side keeps taking requests until the
// next finished frame finds the frame buffer still occupied.
module multichannel_matrix_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // matrix_row, matrix_col, coef_re, coef_im,
                                  // sample_re, sample_im, 4 zero bits
  input  logic [1:0]  in_tuser,   // kind, gap
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_channel, out_re, out_im, 4 zero bits
  output logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [mmm_pkg::CNT_W-1:0] in_ch_r;
  logic [mmm_pkg::CNT_W-1:0] out_ch_r;
  logic                      cplx_r;
  logic [mmm_pkg::IDX_W-1:0] cnt_r;
  logic                      gap_r;
  mmm_pkg::pctl_t            s1_ctl_r;
  mmm_pkg::smp_t             s1_re_r;
  mmm_pkg::smp_t             s1_im_r;
  mmm_pkg::pctl_t            s2_ctl;
  mmm_pkg::cword_t           coef_row [mmm_pkg::LANES];
  mmm_pkg::acc_t             acc_re_nxt [mmm_pkg::LANES];
  mmm_pkg::acc_t             acc_im_nxt [mmm_pkg::LANES];
  logic                      en;
  logic                      busy;
  logic                      acc_in;
  logic                      smp_in;
  logic                      coef_in;
  logic                      first;
  logic                      last;
  logic                      fgap;
  logic [mmm_pkg::CNT_W-1:0] n_in;

  // pipeline holds only when a finished frame meets a full frame buffer
  assign en        = !(s2_ctl.valid && s2_ctl.last && busy);
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign acc_in    = in_tvalid && en;
  assign smp_in    = acc_in && (mmm_pkg::kind_t'(in_tuser[0]) == mmm_pkg::KIND_SAMPLE);
  assign coef_in   = acc_in && (mmm_pkg::kind_t'(in_tuser[0]) == mmm_pkg::KIND_COEF);
  assign n_in      = mmm_pkg::clamp_cnt(in_ch_r);
  assign first     = (cnt_r == '0);
  assign last      = (mmm_pkg::CNT_W'(cnt_r) + mmm_pkg::CNT_W'(1)) >= n_in;
  assign fgap      = (!first && gap_r) || in_tuser[1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r  <= mmm_pkg::CNT_W'(1);
      out_ch_r <= mmm_pkg::CNT_W'(1);
      cplx_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mmm_pkg::cfg_idx_t'(cfg_index))
        mmm_pkg::CFG_IN_CH:  in_ch_r  <= cfg_data;
        mmm_pkg::CFG_OUT_CH: out_ch_r <= cfg_data;
        mmm_pkg::CFG_CPLX:   cplx_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // frame position and gap latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      gap_r <= 1'b0;
    end else if (smp_in) begin
      cnt_r <= last ? '0 : cnt_r + mmm_pkg::IDX_W'(1);
      gap_r <= last ? 1'b0 : fgap;
    end
  end

  // stage 1: sample beside the coefficient row being read
  always_ff @(posedge clk) begin
    if (!rst_n) s1_ctl_r.valid <= 1'b0;
    else if (en) begin
      s1_ctl_r.valid <= smp_in;
      s1_ctl_r.first <= first;
      s1_ctl_r.last  <= last;
      s1_ctl_r.gap   <= fgap;
      s1_ctl_r.cplx  <= cplx_r;
      s1_ctl_r.n_out <= mmm_pkg::clamp_cnt(out_ch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_re_r <= in_tdata[59:44];
      s1_im_r <= cplx_r ? in_tdata[75:60] : '0;
    end
  end

  mmm_coef_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (coef_in),
    .wrow  (in_tdata[3:0]),
    .wcol  (in_tdata[7:4]),
    .wdata ({in_tdata[43:26], in_tdata[25:8]}),
    .re    (en),
    .rrow  (cnt_r),
    .rdata (coef_row)
  );

  mmm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .s1_ctl     (s1_ctl_r),
    .s1_re      (s1_re_r),
    .s1_im      (s1_im_r),
    .coef       (coef_row),
    .s2_ctl     (s2_ctl),
    .acc_re_nxt (acc_re_nxt),
    .acc_im_nxt (acc_im_nxt)
  );

  mmm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (en && s2_ctl.valid && s2_ctl.last),
    .ctl        (s2_ctl),
    .sum_re     (acc_re_nxt),
    .sum_im     (acc_im_nxt),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hw/rtl/mmm_checker.sv
`include "multichannel_matrix_mixer_macros.svh"

module mmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [79:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [4:0]  cfg_data
);

  // no result right after reset
  `MMM_CHK_RST(a_rst_quiet, !rst_n, !out_tvalid)
  // a stalled result holds
  `MMM_CHK_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // results of a frame leave back to back with rising channel numbers
  `MMM_CHK_NEXT(a_walk, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[3:0] == 4'($past(out_tdata[3:0]) + 4'd1)))
  // a result right after a frame's last one is channel zero
  `MMM_CHK_NEXT(a_start, out_tvalid && out_tready && out_tlast, !out_tvalid || (out_tdata[3:0] == 4'd0))

endmodule

bind multichannel_matrix_mixer mmm_checker u_mmm_checker (.*);
